// ===== rtl/core/ipv4hv_pkg.sv =====
// Shared types and constants for the IPv4 header validator.
package ipv4hv_pkg;

    // Verdict codes.
    localparam logic [2:0] STATUS_ACCEPT      = 3'd0;
    localparam logic [2:0] STATUS_TOO_SHORT   = 3'd1;
    localparam logic [2:0] STATUS_BAD_VERSION = 3'd2;
    localparam logic [2:0] STATUS_BAD_HLEN    = 3'd3;
    localparam logic [2:0] STATUS_BAD_TLEN    = 3'd4;
    localparam logic [2:0] STATUS_BAD_CSUM    = 3'd5;
    localparam logic [2:0] STATUS_NOT_FOR_US  = 3'd6;
    localparam logic [2:0] STATUS_UNKNOWN_PRO = 3'd7;

    // Protocol classes.
    localparam logic [1:0] CLASS_ICMP = 2'd0;
    localparam logic [1:0] CLASS_UDP  = 2'd1;
    localparam logic [1:0] CLASS_TCP  = 2'd2;

    // IP protocol numbers.
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [3:0]  IPV4_VER       = 4'd4;
    localparam logic [5:0]  MIN_HEADER     = 6'd20;
    localparam logic [31:0] BROADCAST_ADDR = 32'hFFFF_FFFF;

    // Byte positions of header fields.
    localparam logic [5:0] POS_VER_IHL  = 6'd0;
    localparam logic [5:0] POS_TLEN_HI  = 6'd2;
    localparam logic [5:0] POS_TLEN_LO  = 6'd3;
    localparam logic [5:0] POS_PROTOCOL = 6'd9;
    localparam logic [5:0] POS_CSUM_HI  = 6'd10;
    localparam logic [5:0] POS_CSUM_LO  = 6'd11;
    localparam logic [5:0] POS_DST_LO   = 6'd16;
    localparam logic [5:0] POS_DST_HI   = 6'd19;

    // Header fields and running checksum as seen after the current word.
    typedef struct packed {
        logic [3:0]  version;
        logic [5:0]  header_bytes;
        logic [15:0] total_length;
        logic [15:0] stored_checksum;
        logic [7:0]  protocol;
        logic [31:0] destination;
        logic [15:0] sum;
    } pkt_view_t;

endpackage

// ===== rtl/core/ipv4_header_validator_top.sv =====
// Top level of the IPv4 header validator: word intake, verdict and result register.
// The verdict is loaded into the result register when the word carrying tlast leaves the input register.
// Throughput: one word per cycle through the input register and the result register.
// A result held by a stalled consumer stalls intake only once the next final word
// sits in the input register.
// Reset (rst_n, asynchronous) clears all packet state, the local address and both valids.
module ipv4_header_validator_top #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [31:0] cfg_wdata,     // local_address
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // data_byte[7:0]
    input  logic        s_tlast,       // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata        // status[2:0], protocol_class[4:3],
                                       // header_length[10:5], payload byte count[26:11]
);

    logic [31:0] local_address_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic [1:0]  class_reg;
    logic [5:0]  hlen_reg;
    logic [15:0] payload_reg;

    logic out_free;
    logic proc;

    logic [LENGTH_BITS-1:0] count;
    logic [LENGTH_BITS-1:0] count_next;
    ipv4hv_pkg::pkt_view_t  view_next;

    logic [15:0] n16;
    logic [15:0] hb16;
    logic [2:0]  status_next;
    logic [1:0]  class_next;
    logic [15:0] payload_next;

    // Handshake: a final word waits only for room in the result register.
    assign out_free = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || proc;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            local_address_reg <= '0;
        else if (cfg_wen)
            local_address_reg <= cfg_wdata;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ipv4hv_tracker #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (proc),
        .data_byte  (in_byte_reg),
        .last       (in_last_reg),
        .count      (count),
        .count_next (count_next),
        .view_next  (view_next)
    );

    assign n16  = 16'(count_next);
    assign hb16 = 16'(view_next.header_bytes);

    // Verdict: the first failing check wins.
    always_comb
    begin
        class_next = ipv4hv_pkg::CLASS_ICMP;
        if (n16 < 16'(ipv4hv_pkg::MIN_HEADER))
            status_next = ipv4hv_pkg::STATUS_TOO_SHORT;
        else if (view_next.version != ipv4hv_pkg::IPV4_VER)
            status_next = ipv4hv_pkg::STATUS_BAD_VERSION;
        else if (view_next.header_bytes < ipv4hv_pkg::MIN_HEADER)
            status_next = ipv4hv_pkg::STATUS_BAD_HLEN;
        else if (view_next.total_length < hb16)
            status_next = ipv4hv_pkg::STATUS_BAD_TLEN;
        else if (n16 < hb16)
            status_next = ipv4hv_pkg::STATUS_TOO_SHORT;
        else if (~view_next.sum != view_next.stored_checksum)
            status_next = ipv4hv_pkg::STATUS_BAD_CSUM;
        else if (view_next.destination != local_address_reg &&
                 view_next.destination != ipv4hv_pkg::BROADCAST_ADDR)
            status_next = ipv4hv_pkg::STATUS_NOT_FOR_US;
        else if (view_next.protocol == ipv4hv_pkg::PROTO_ICMP)
            status_next = ipv4hv_pkg::STATUS_ACCEPT;
        else if (view_next.protocol == ipv4hv_pkg::PROTO_UDP)
        begin
            status_next = ipv4hv_pkg::STATUS_ACCEPT;
            class_next  = ipv4hv_pkg::CLASS_UDP;
        end
        else if (view_next.protocol == ipv4hv_pkg::PROTO_TCP)
        begin
            status_next = ipv4hv_pkg::STATUS_ACCEPT;
            class_next  = ipv4hv_pkg::CLASS_TCP;
        end
        else
            status_next = ipv4hv_pkg::STATUS_UNKNOWN_PRO;
    end

    assign payload_next = (n16 > hb16) ? (n16 - hb16) : 16'd0;

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc && in_last_reg)
        begin
            status_reg  <= status_next;
            class_reg   <= class_next;
            hlen_reg    <= view_next.header_bytes;
            payload_reg <= payload_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, payload_reg, hlen_reg, class_reg, status_reg};

    // Checks on the verdict logic.
    a_accept_hlen: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status_reg == ipv4hv_pkg::STATUS_ACCEPT) |->
            hlen_reg >= ipv4hv_pkg::MIN_HEADER)
        else $error("accepted packet with short header");

    a_drop_class: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status_reg != ipv4hv_pkg::STATUS_ACCEPT) |->
            class_reg == ipv4hv_pkg::CLASS_ICMP)
        else $error("dropped packet carries a protocol class");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_last_reg) |=> count == '0)
        else $error("byte count not cleared after final word");

    a_final_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_last_reg) |=> out_valid_reg)
        else $error("final word did not produce a result");

endmodule

// ===== rtl/core/ipv4hv_tracker.sv =====
// Per-packet header field capture and running ones'-complement checksum.
module ipv4hv_tracker #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  logic [7:0]                data_byte,
    input  logic                      last,
    output logic [LENGTH_BITS-1:0]    count,
    output logic [LENGTH_BITS-1:0]    count_next,
    output ipv4hv_pkg::pkt_view_t     view_next
);

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

    logic [LENGTH_BITS-1:0] count_reg;
    logic [7:0]             hold_reg;
    logic [7:0]             hold_next;
    ipv4hv_pkg::pkt_view_t  view_reg;

    logic       pos_small;
    logic [5:0] pos6;
    logic [7:0] sum_byte;
    logic [16:0] sum_wide;
    logic       in_header;

    assign count     = count_reg;
    assign pos_small = (count_reg[LENGTH_BITS-1:6] == '0);
    assign pos6      = count_reg[5:0];

    // Saturating byte counter.
    assign count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    // Field capture and checksum update for the current word.
    always_comb
    begin
        view_next = view_reg;
        hold_next = hold_reg;
        sum_byte  = data_byte;
        sum_wide  = '0;
        if (pos_small)
        begin
            if (pos6 == ipv4hv_pkg::POS_VER_IHL)
            begin
                view_next.version      = data_byte[7:4];
                view_next.header_bytes = {data_byte[3:0], 2'b00};
            end
            else if (pos6 == ipv4hv_pkg::POS_TLEN_HI)
                view_next.total_length[15:8] = data_byte;
            else if (pos6 == ipv4hv_pkg::POS_TLEN_LO)
                view_next.total_length[7:0] = data_byte;
            else if (pos6 == ipv4hv_pkg::POS_PROTOCOL)
                view_next.protocol = data_byte;
            else if (pos6 == ipv4hv_pkg::POS_CSUM_HI)
            begin
                view_next.stored_checksum[15:8] = data_byte;
                sum_byte = 8'd0;
            end
            else if (pos6 == ipv4hv_pkg::POS_CSUM_LO)
            begin
                view_next.stored_checksum[7:0] = data_byte;
                sum_byte = 8'd0;
            end
            else if (pos6 >= ipv4hv_pkg::POS_DST_LO && pos6 <= ipv4hv_pkg::POS_DST_HI)
                view_next.destination = {view_reg.destination[23:0], data_byte};
        end

        // Only bytes inside the declared header enter the checksum.
        in_header = pos_small && (pos6 < view_next.header_bytes);
        if (in_header)
        begin
            if (!pos6[0])
                hold_next = sum_byte;
            else
            begin
                sum_wide = {1'b0, view_reg.sum} + {1'b0, hold_reg, sum_byte};
                view_next.sum = sum_wide[15:0] + {15'd0, sum_wide[16]};
            end
        end
    end

    // State registers; a final word clears the packet state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            hold_reg  <= '0;
            view_reg  <= '0;
        end
        else if (take)
        begin
            if (last)
            begin
                count_reg <= '0;
                hold_reg  <= '0;
                view_reg  <= '0;
            end
            else
            begin
                count_reg <= count_next;
                hold_reg  <= hold_next;
                view_reg  <= view_next;
            end
        end
    end

endmodule

// ===== dv/ipv4hv_verdict_checker.sv =====
// Scoreboard for the IPv4 header validator: predicts each verdict from the byte stream and compares.
module ipv4hv_verdict_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          mismatch_count,
    output int          verdicts_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  proto_class;
        logic [5:0]  hdr_len;
        logic [15:0] pay_bytes;
    } verdict_t;

    // Mirror of the packet parser and its configuration.
    ipv4hv_pkg::pkt_view_t hdr_view;
    logic [15:0] rx_count;
    logic [7:0]  even_byte;
    logic [31:0] local_addr;
    verdict_t    due_verdicts[$];
    int          errors;

    task automatic clear_packet();
        hdr_view  = '0;
        rx_count  = '0;
        even_byte = '0;
    endtask

    // Record the header fields and fold the byte into the running checksum.
    task automatic absorb_byte(input logic [7:0] b);
        logic [15:0] pos;
        logic [7:0]  v;
        logic [16:0] s;
        pos = rx_count;
        v   = b;
        if (pos == ipv4hv_pkg::POS_VER_IHL)
        begin
            hdr_view.version      = b[7:4];
            hdr_view.header_bytes = {b[3:0], 2'b00};
        end
        else if (pos == ipv4hv_pkg::POS_TLEN_HI)
            hdr_view.total_length[15:8] = b;
        else if (pos == ipv4hv_pkg::POS_TLEN_LO)
            hdr_view.total_length[7:0] = b;
        else if (pos == ipv4hv_pkg::POS_PROTOCOL)
            hdr_view.protocol = b;
        else if (pos == ipv4hv_pkg::POS_CSUM_HI)
        begin
            hdr_view.stored_checksum[15:8] = b;
            v = 8'h00;
        end
        else if (pos == ipv4hv_pkg::POS_CSUM_LO)
        begin
            hdr_view.stored_checksum[7:0] = b;
            v = 8'h00;
        end
        else if (pos >= ipv4hv_pkg::POS_DST_LO && pos <= ipv4hv_pkg::POS_DST_HI)
            hdr_view.destination = {hdr_view.destination[23:0], b};

        // Only bytes inside the header take part in the checksum.
        if (pos < hdr_view.header_bytes)
        begin
            if (!pos[0])
                even_byte = v;
            else
            begin
                s = {1'b0, hdr_view.sum} + {1'b0, even_byte, v};
                hdr_view.sum = s[15:0] + {15'd0, s[16]};
            end
        end

        if (rx_count != COUNT_MAX)
            rx_count = rx_count + 16'd1;
    endtask

    // Apply the checks in priority order and report the first one that fails.
    function automatic verdict_t judge_packet();
        verdict_t r;
        logic [15:0] n;
        n = rx_count;
        r.proto_class = ipv4hv_pkg::CLASS_ICMP;
        if (n < ipv4hv_pkg::MIN_HEADER)
            r.status = ipv4hv_pkg::STATUS_TOO_SHORT;
        else if (hdr_view.version != ipv4hv_pkg::IPV4_VER)
            r.status = ipv4hv_pkg::STATUS_BAD_VERSION;
        else if (hdr_view.header_bytes < ipv4hv_pkg::MIN_HEADER)
            r.status = ipv4hv_pkg::STATUS_BAD_HLEN;
        else if (hdr_view.total_length < hdr_view.header_bytes)
            r.status = ipv4hv_pkg::STATUS_BAD_TLEN;
        else if (n < hdr_view.header_bytes)
            r.status = ipv4hv_pkg::STATUS_TOO_SHORT;
        else if (16'(~hdr_view.sum) != hdr_view.stored_checksum)
            r.status = ipv4hv_pkg::STATUS_BAD_CSUM;
        else if (hdr_view.destination != local_addr &&
                 hdr_view.destination != ipv4hv_pkg::BROADCAST_ADDR)
            r.status = ipv4hv_pkg::STATUS_NOT_FOR_US;
        else
        begin
            r.status = ipv4hv_pkg::STATUS_ACCEPT;
            case (hdr_view.protocol)
                ipv4hv_pkg::PROTO_ICMP: r.proto_class = ipv4hv_pkg::CLASS_ICMP;
                ipv4hv_pkg::PROTO_UDP:  r.proto_class = ipv4hv_pkg::CLASS_UDP;
                ipv4hv_pkg::PROTO_TCP:  r.proto_class = ipv4hv_pkg::CLASS_TCP;
                default:                r.status = ipv4hv_pkg::STATUS_UNKNOWN_PRO;
            endcase
        end
        r.hdr_len   = hdr_view.header_bytes;
        r.pay_bytes = (n > hdr_view.header_bytes) ? n - hdr_view.header_bytes : 16'd0;
        return r;
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // Watch the configuration write, the byte input and the verdict output.
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            local_addr = '0;
            clear_packet();
            due_verdicts.delete();
            errors = 0;
            mismatch_count <= 0;
            verdicts_outstanding <= 0;
        end
        else
        begin
            if (cfg_wen)
                local_addr = cfg_wdata;

            if (s_tvalid && s_tready)
            begin
                absorb_byte(s_tdata);
                if (s_tlast)
                begin
                    due_verdicts.push_back(judge_packet());
                    clear_packet();
                end
            end

            if (m_tvalid && m_tready)
            begin
                if (due_verdicts.size() == 0)
                begin
                    $display("%0t: verdict expected none, got %h", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = due_verdicts.pop_front();
                    check_field("status", want.status, m_tdata[2:0]);
                    check_field("protocol_class", want.proto_class, m_tdata[4:3]);
                    check_field("header_length", want.hdr_len, m_tdata[10:5]);
                    check_field("payload_length", want.pay_bytes, m_tdata[26:11]);
                end
            end

            mismatch_count <= errors;
            verdicts_outstanding <= due_verdicts.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the IPv4 header validator: clock, reset, packet stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 40000;
    localparam int IDLE_PCT    = 21;

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    int          mismatch_count;
    int          verdicts_outstanding;
    int          send_idle_pct;
    int          take_idle_pct;
    int          cycles;
    logic [31:0] own_addr;
    logic [7:0]  frame_q[$];

    ipv4_header_validator_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ipv4hv_verdict_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_wen             (cfg_wen),
        .cfg_wdata           (cfg_wdata),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tlast             (s_tlast),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .mismatch_count      (mismatch_count),
        .verdicts_outstanding(verdicts_outstanding)
    );

    // Clock with a 2 ns period.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("ipv4_header_validator_top: mismatch");
            $finish;
        end
    end

    // The verdict consumer stalls at random.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // Send the frame in frame_q one word per handshake, with random gaps.
    task automatic send_frame();
        int i;
        for (i = 0; i < frame_q.size(); i++)
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= frame_q[i];
            s_tlast  <= (i == frame_q.size() - 1);
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
        end
    endtask

    // Build a header with the given fields, random filler, an optional payload
    // and an optional cut to a shorter frame.
    task automatic build_frame(input logic [3:0] version, input logic [3:0] ihl,
                               input logic [15:0] tlen_field, input logic [7:0] proto,
                               input logic [31:0] dst, input bit csum_ok,
                               input int extra, input int keep);
        int          hdr;
        int          span;
        int          i;
        int unsigned sum;
        logic [15:0] csum;
        hdr  = int'(ihl) * 4;
        span = (hdr > 20) ? hdr : 20;
        frame_q.delete();
        for (i = 0; i < span + extra; i++)
            frame_q.push_back(8'($urandom));
        frame_q[0]  = {version, ihl};
        frame_q[2]  = tlen_field[15:8];
        frame_q[3]  = tlen_field[7:0];
        frame_q[9]  = proto;
        frame_q[10] = 8'h00;
        frame_q[11] = 8'h00;
        for (i = 0; i < 4; i++)
            frame_q[16 + i] = dst[31 - 8 * i -: 8];

        // Ones'-complement sum over the header with the checksum field at zero.
        sum = 0;
        for (i = 0; i < hdr; i += 2)
            sum += {frame_q[i], frame_q[i + 1]};
        while (sum > 32'hFFFF)
            sum = (sum & 32'hFFFF) + (sum >> 16);
        csum = ~sum[15:0];
        if (!csum_ok)
            csum ^= 16'd1 << $urandom_range(15);
        frame_q[10] = csum[15:8];
        frame_q[11] = csum[7:0];

        if (keep > 0)
            while (frame_q.size() > keep)
                void'(frame_q.pop_back());
    endtask

    // Mostly well-formed packets, some with one fault, a few pure noise.
    task automatic random_frame();
        int          pick;
        int          ihl;
        int          hdr;
        int          keep;
        int          i;
        logic [3:0]  ver;
        logic [15:0] tlen;
        logic [7:0]  proto;
        logic [31:0] dst;
        bit          ok;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            frame_q.delete();
            for (i = $urandom_range(40, 1); i > 0; i--)
                frame_q.push_back(8'($urandom));
            send_frame();
            return;
        end

        ihl  = ($urandom_range(3) == 0) ? $urandom_range(15, 6) : 5;
        hdr  = ihl * 4;
        ver  = ipv4hv_pkg::IPV4_VER;
        tlen = 16'($urandom_range(65535, hdr));
        ok   = 1'b1;
        keep = 0;
        case ($urandom_range(7))
            0, 1:    proto = ipv4hv_pkg::PROTO_ICMP;
            2, 3:    proto = ipv4hv_pkg::PROTO_UDP;
            4, 5:    proto = ipv4hv_pkg::PROTO_TCP;
            default: proto = 8'($urandom);
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: dst = own_addr;
            6, 7:             dst = ipv4hv_pkg::BROADCAST_ADDR;
            default:          dst = $urandom;
        endcase

        if (pick < 30)
        begin
            case ($urandom_range(4))
                0: ver ^= 4'($urandom_range(15, 1));
                1: ihl = $urandom_range(4);
                2: tlen = 16'($urandom_range(hdr - 1));
                3: ok = 1'b0;
                default:
                    keep = (ihl > 5 && $urandom_range(1)) ? $urandom_range(hdr - 1, 20)
                                                          : $urandom_range(19, 1);
            endcase
        end

        build_frame(ver, 4'(ihl), tlen, proto, dst, ok, $urandom_range(24), keep);
        send_frame();
    endtask

    task automatic write_local(input logic [31:0] addr);
        cfg_wen   <= 1'b1;
        cfg_wdata <= addr;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        own_addr = addr;
    endtask

    // Let every outstanding verdict arrive, then let the pipeline settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (verdicts_outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] addr_plan[4];
        int          phase;
        int          phase_bytes;

        send_idle_pct = IDLE_PCT;
        take_idle_pct = IDLE_PCT;
        rst_n     <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed packets: each protocol, each fault and the field extremes.
        write_local($urandom);
        build_frame(ipv4hv_pkg::IPV4_VER, 4'd5, 16'd20, ipv4hv_pkg::PROTO_ICMP, own_addr,
                    1'b1, 0, 0);
        send_frame();
        build_frame(ipv4hv_pkg::IPV4_VER, 4'd15, 16'hFFFF, ipv4hv_pkg::PROTO_UDP,
                    ipv4hv_pkg::BROADCAST_ADDR, 1'b1, 8, 0);
        send_frame();
        build_frame(ipv4hv_pkg::IPV4_VER, 4'd6, 16'd100, ipv4hv_pkg::PROTO_TCP, own_addr,
                    1'b1, 3, 0);
        send_frame();
        build_frame(ipv4hv_pkg::IPV4_VER, 4'd5, 16'd40, 8'h00, own_addr, 1'b1, 2, 0);
        send_frame();
        build_frame(ipv4hv_pkg::IPV4_VER, 4'd5, 16'd40, 8'hFF, ipv4hv_pkg::BROADCAST_ADDR,
                    1'b1, 2, 0);
        send_frame();
        // A single-word packet and one a word short of a minimal header.
        build_frame(ipv4hv_pkg::IPV4_VER, 4'd5, 16'd40, ipv4hv_pkg::PROTO_UDP, own_addr,
                    1'b1, 0, 1);
        send_frame();
        build_frame(ipv4hv_pkg::IPV4_VER, 4'd5, 16'd40, ipv4hv_pkg::PROTO_UDP, own_addr,
                    1'b1, 0, 19);
        send_frame();
        build_frame(4'd0, 4'd5, 16'd40, ipv4hv_pkg::PROTO_UDP, own_addr, 1'b1, 0, 0);
        send_frame();
        build_frame(4'hF, 4'd5, 16'd40, ipv4hv_pkg::PROTO_UDP, own_addr, 1'b1, 0, 0);
        send_frame();
        build_frame(ipv4hv_pkg::IPV4_VER, 4'd0, 16'd40, ipv4hv_pkg::PROTO_UDP, own_addr,
                    1'b1, 0, 0);
        send_frame();
        build_frame(ipv4hv_pkg::IPV4_VER, 4'd4, 16'd40, ipv4hv_pkg::PROTO_UDP, own_addr,
                    1'b1, 0, 0);
        send_frame();
        build_frame(ipv4hv_pkg::IPV4_VER, 4'd5, 16'd0, ipv4hv_pkg::PROTO_UDP, own_addr,
                    1'b1, 0, 0);
        send_frame();
        build_frame(ipv4hv_pkg::IPV4_VER, 4'd15, 16'd59, ipv4hv_pkg::PROTO_TCP, own_addr,
                    1'b1, 0, 0);
        send_frame();
        // Header length says 60 but the packet stops inside the options.
        build_frame(ipv4hv_pkg::IPV4_VER, 4'd15, 16'd60, ipv4hv_pkg::PROTO_TCP, own_addr,
                    1'b1, 0, 40);
        send_frame();
        build_frame(ipv4hv_pkg::IPV4_VER, 4'd5, 16'd40, ipv4hv_pkg::PROTO_ICMP, own_addr,
                    1'b0, 0, 0);
        send_frame();
        build_frame(ipv4hv_pkg::IPV4_VER, 4'd5, 16'd40, ipv4hv_pkg::PROTO_ICMP, ~own_addr,
                    1'b1, 0, 0);
        send_frame();

        // Random packets under several local addresses, extremes included.
        addr_plan[0] = 32'h0000_0000;
        addr_plan[1] = 32'hFFFF_FFFF;
        addr_plan[2] = $urandom;
        addr_plan[3] = $urandom;
        for (phase = 0; phase < 4; phase++)
        begin
            drain_results();
            write_local(addr_plan[phase]);
            if (phase == 2)
            begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            phase_bytes = 0;
            while (phase_bytes < 250)
            begin
                if (phase == 2 && phase_bytes >= 125)
                begin
                    send_idle_pct = IDLE_PCT;
                    take_idle_pct = IDLE_PCT;
                end
                random_frame();
                phase_bytes += frame_q.size();
            end
        end

        drain_results();
        if (mismatch_count == 0)
            $display("ipv4_header_validator_top: match");
        else
            $display("ipv4_header_validator_top: mismatch");
        $finish;
    end

endmodule
